@@ sv/gso3_pkg.sv @@
// Shared constants and status codes for the 3-vector Gram-Schmidt block.
package gso3_pkg;

  parameter int DATA_WIDTH_DEF = 32;   // default input component width
  parameter int LIMB           = 32;   // partial product operand width
  parameter int UNIT_W         = 32;   // width of one unit component
  parameter int FRAC           = 30;   // fraction bits of the Q1.30 result
  parameter int WB             = 31;   // width of a normalised magnitude
  parameter int SQ_W           = 64;   // sum of squares
  parameter int ROOT_W         = 32;   // integer square root
  parameter int SQRT_STEPS     = 32;
  parameter int DIV_STEPS      = 32;
  parameter int NUM_W          = 62;   // rounded dividend
  parameter int STATUS_W       = 2;

  localparam logic [UNIT_W-1:0] ONE_Q30 = UNIT_W'(1) << FRAC;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_A_ZERO   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RES_ZERO = 2'd2;

endpackage

@@ sv/gram_schmidt_orthonormalise3_core.sv @@
// Top level: pipelined Gram-Schmidt orthonormalisation of b against a.
//
// Input stream (s_*): one word holds the vectors a and b as six signed
// DATA_WIDTH components. Output stream (m_*): one word holds the unit vector
// in signed Q1.30, with a status code on tuser (ok, a zero, residual zero);
// when the status is not ok the three components are zero.
// Three lanes, one per axis, run the multipliers, normalising shift and
// dividers side by side; merging stages form a.a, a.b, the common bit length
// and the sum of squares, and one shared square-root pipeline serves all.
// The 32-stage square root and the 32-stage dividers make up most of the
// pipeline depth.
// Throughput: one word per cycle while the pipeline is not stalled.
// A finished result waits in the output register; the pipeline stalls only
// when that register is full, not taken and a further result is due.
// Reset clears all valid flags; data registers are not reset.
module gram_schmidt_orthonormalise3_core
  import gso3_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_tvalid_i,
  output logic s_tready_o,
  // a_x, a_y, a_z, b_x, b_y, b_z from bit 0 up, zero padded to bytes
  input  logic [((6*DATA_WIDTH+7)/8)*8-1:0] s_tdata_i,
  output logic m_tvalid_o,
  input  logic m_tready_i,
  // unit_x, unit_y, unit_z from bit 0 up
  output logic [3*UNIT_W-1:0] m_tdata_o,
  // status
  output logic [STATUS_W-1:0] m_tuser_o
);

  localparam int DW  = DATA_WIDTH;
  localparam int AAW = 2*DW;          // a.a and |a.b|
  localparam int PW  = 3*DW;          // second products
  localparam int VW  = 3*DW + 2;      // residual, signed
  localparam int MW  = 3*DW + 1;      // residual magnitude
  localparam int NC  = (MW + 15) / 16;
  localparam int LW  = $clog2(NC*16 + 1);
  localparam int XW  = MW + WB;
  localparam int YW  = WB + 15;

  // stage numbers
  localparam int ST_IN  = 0;
  localparam int ST_P1  = 2;
  localparam int ST_DOT = 3;
  localparam int ST_P2  = 5;
  localparam int ST_V   = 6;
  localparam int ST_M   = 7;
  localparam int ST_CH  = 8;
  localparam int ST_L   = 9;
  localparam int ST_CO  = 10;
  localparam int ST_W   = 11;
  localparam int ST_SQ  = 12;
  localparam int ST_SUM = 13;
  localparam int ST_S   = ST_SUM + SQRT_STEPS;
  localparam int ST_N   = ST_S + 1;
  localparam int ST_Q   = ST_N + DIV_STEPS;

  typedef struct packed {
    logic [DW-1:0] am;
    logic [DW-1:0] bm;
    logic          sa;
    logic          sb;
  } lane_t;

  typedef struct packed {
    logic sab;
    logic s1;
  } dot_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [2:0]          neg;
  } side_t;

  function automatic logic [4:0] bitlen16(logic [15:0] x);
    logic [4:0] n;
    n = '0;
    for (int b = 0; b < 16; b++) begin
      if (x[b]) n = 5'(b + 1);
    end
    return n;
  endfunction

  // handshake and stall
  logic [ST_Q:0] vld_q;
  logic          out_vld_q;
  logic          out_take, adv;

  assign out_take   = !out_vld_q || m_tready_i;
  assign adv        = out_take || !vld_q[ST_Q];
  assign s_tready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (adv) begin
        vld_q <= {vld_q[ST_Q-1:0], s_tvalid_i};
      end
      if (out_take) begin
        out_vld_q <= vld_q[ST_Q];
      end
    end
  end

  // input stage: magnitudes and signs per lane
  lane_t li_d [3];
  lane_t li_q [ST_IN:ST_P2][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      li_d[i].sa = s_tdata_i[i*DW + DW-1];
      li_d[i].sb = s_tdata_i[(i+3)*DW + DW-1];
      li_d[i].am = li_d[i].sa ? (DW'(0) - s_tdata_i[i*DW +: DW]) : s_tdata_i[i*DW +: DW];
      li_d[i].bm = li_d[i].sb ? (DW'(0) - s_tdata_i[(i+3)*DW +: DW])
                              : s_tdata_i[(i+3)*DW +: DW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      li_q[ST_IN] <= li_d;
      for (int k = ST_IN+1; k <= ST_P2; k++) li_q[k] <= li_q[k-1];
    end
  end

  // lane products a_i*a_i and a_i*b_i
  logic [2*DW-1:0] sq_p [3];
  logic [2*DW-1:0] ab_p [3];

  for (genvar i = 0; i < 3; i++) begin : g_mul1
    gso3_mul #(.AW(DW), .BW(DW)) u_sq (
      .clk_i(clk_i), .en_i(adv),
      .a_i(li_q[ST_IN][i].am), .b_i(li_q[ST_IN][i].am), .p_o(sq_p[i]));
    gso3_mul #(.AW(DW), .BW(DW)) u_ab (
      .clk_i(clk_i), .en_i(adv),
      .a_i(li_q[ST_IN][i].am), .b_i(li_q[ST_IN][i].bm), .p_o(ab_p[i]));
  end

  // merge: a.a and a.b
  logic [AAW+1:0] aa_sum, ab_sum, ab_mag;
  logic [AAW-1:0] aa_q, abm_q;
  dot_t           dot_d;
  dot_t           dot_q [ST_DOT:ST_P2];

  always_comb begin
    aa_sum = '0;
    ab_sum = '0;
    for (int i = 0; i < 3; i++) begin
      aa_sum = aa_sum + (AAW+2)'(sq_p[i]);
      if (li_q[ST_P1][i].sa ^ li_q[ST_P1][i].sb) ab_sum = ab_sum - (AAW+2)'(ab_p[i]);
      else ab_sum = ab_sum + (AAW+2)'(ab_p[i]);
    end
    dot_d.sab = ab_sum[AAW+1];
    ab_mag    = dot_d.sab ? ((AAW+2)'(0) - ab_sum) : ab_sum;
    dot_d.s1  = (aa_sum == '0);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      aa_q          <= aa_sum[AAW-1:0];
      abm_q         <= ab_mag[AAW-1:0];
      dot_q[ST_DOT] <= dot_d;
      for (int k = ST_DOT+1; k <= ST_P2; k++) dot_q[k] <= dot_q[k-1];
    end
  end

  // lane products (a.a)*b_i and (a.b)*a_i
  logic [PW-1:0] p1 [3];
  logic [PW-1:0] p2 [3];

  for (genvar i = 0; i < 3; i++) begin : g_mul2
    gso3_mul #(.AW(AAW), .BW(DW)) u_p1 (
      .clk_i(clk_i), .en_i(adv),
      .a_i(aa_q), .b_i(li_q[ST_DOT][i].bm), .p_o(p1[i]));
    gso3_mul #(.AW(AAW), .BW(DW)) u_p2 (
      .clk_i(clk_i), .en_i(adv),
      .a_i(abm_q), .b_i(li_q[ST_DOT][i].am), .p_o(p2[i]));
  end

  // residual v_i = (a.a) b_i - (a.b) a_i
  logic [VW-1:0] t1 [3];
  logic [VW-1:0] t2 [3];
  logic [VW-1:0] v_q [3];
  logic          s1_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t1[i] = li_q[ST_P2][i].sb ? (VW'(0) - VW'(p1[i])) : VW'(p1[i]);
      t2[i] = (dot_q[ST_P2].sab ^ li_q[ST_P2][i].sa) ? (VW'(0) - VW'(p2[i])) : VW'(p2[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) v_q[i] <= t1[i] - t2[i];
      s1_q <= dot_q[ST_P2].s1;
    end
  end

  // magnitudes, signs, status
  logic [VW-1:0]  v_abs [3];
  side_t          side_m_d;
  side_t          side_q [ST_M:ST_Q];
  logic [MW-1:0]  m_q [ST_M:ST_L][3];

  always_comb begin
    side_m_d.status = s1_q ? ST_A_ZERO : ST_OK;
    for (int i = 0; i < 3; i++) begin
      side_m_d.neg[i] = v_q[i][VW-1];
      v_abs[i] = v_q[i][VW-1] ? (VW'(0) - v_q[i]) : v_q[i];
    end
  end

  // largest bit length: per-chunk search, then chunk pick
  logic [NC*16-1:0] or_w;
  logic [NC-1:0]    nz_q;
  logic [4:0]       len_q [NC];
  logic [LW-1:0]    l_d, l_q;
  side_t            side_l_d;

  always_comb begin
    or_w = (NC*16)'(m_q[ST_M][0] | m_q[ST_M][1] | m_q[ST_M][2]);
    l_d  = '0;
    for (int c = 0; c < NC; c++) begin
      if (nz_q[c]) l_d = LW'(c*16) + LW'(len_q[c]);
    end
    // empty residual found once the bit length is known
    side_l_d = side_q[ST_CH];
    if (side_q[ST_CH].status == ST_OK && l_d == '0) side_l_d.status = ST_RES_ZERO;
  end

  // normalising shift: whole 16-bit steps, then the rest
  logic [XW-1:0] x_w [3];
  logic [XW-1:0] y_full [3];
  logic [YW-1:0] y_q [3];
  logic [YW-1:0] y_sh [3];
  logic [3:0]    lo_q;
  logic [WB-1:0] w_q [ST_W:ST_SUM][3];
  logic [2*WB-1:0] sq_q [3];
  logic [SQ_W-1:0] wsum_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      x_w[i]    = {m_q[ST_L][i], WB'(0)};
      y_full[i] = x_w[i] >> {l_q[LW-1:4], 4'b0};
      y_sh[i]   = y_q[i] >> lo_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        m_q[ST_M][i] <= v_abs[i][MW-1:0];
        for (int k = ST_M+1; k <= ST_L; k++) m_q[k][i] <= m_q[k-1][i];
        y_q[i]       <= y_full[i][YW-1:0];
        w_q[ST_W][i] <= y_sh[i][WB-1:0];
        for (int k = ST_W+1; k <= ST_SUM; k++) w_q[k][i] <= w_q[k-1][i];
        sq_q[i]      <= w_q[ST_W][i] * w_q[ST_W][i];
      end
      for (int c = 0; c < NC; c++) begin
        nz_q[c]  <= |or_w[c*16 +: 16];
        len_q[c] <= bitlen16(or_w[c*16 +: 16]);
      end
      l_q    <= l_d;
      lo_q   <= l_q[3:0];
      wsum_q <= SQ_W'(sq_q[0]) + SQ_W'(sq_q[1]) + SQ_W'(sq_q[2]);

      side_q[ST_M]  <= side_m_d;
      side_q[ST_CH] <= side_q[ST_M];
      side_q[ST_L]  <= side_l_d;
      for (int k = ST_L+1; k <= ST_Q; k++) side_q[k] <= side_q[k-1];
    end
  end

  // shared square root of the sum of squares
  logic [ROOT_W-1:0] s_root;
  logic [3*WB-1:0]   w_tag;

  gso3_isqrt #(.TW(3*WB)) u_isqrt (
    .clk_i(clk_i), .en_i(adv),
    .x_i(wsum_q), .tag_i({w_q[ST_SUM][2], w_q[ST_SUM][1], w_q[ST_SUM][0]}),
    .s_o(s_root), .tag_o(w_tag));

  // rounded dividends, then one divider per lane
  logic [NUM_W-1:0]  n_q [3];
  logic [ROOT_W-1:0] den_q;
  logic [UNIT_W-1:0] quo [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        n_q[i] <= NUM_W'({w_tag[i*WB +: WB], FRAC'(0)}) + NUM_W'(s_root >> 1);
      end
      den_q <= s_root;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    gso3_div u_div (
      .clk_i(clk_i), .en_i(adv),
      .num_i(n_q[i]), .den_i(den_q), .q_o(quo[i]));
  end

  // output register: sign, forced zero on bad status
  logic [3*UNIT_W-1:0] unit_d, unit_q;
  logic [STATUS_W-1:0] status_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (side_q[ST_Q].status != ST_OK) unit_d[i*UNIT_W +: UNIT_W] = '0;
      else if (side_q[ST_Q].neg[i]) unit_d[i*UNIT_W +: UNIT_W] = UNIT_W'(0) - quo[i];
      else unit_d[i*UNIT_W +: UNIT_W] = quo[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take) begin
      unit_q   <= unit_d;
      status_q <= side_q[ST_Q].status;
    end
  end

  assign m_tvalid_o = out_vld_q;
  assign m_tdata_o  = unit_q;
  assign m_tuser_o  = status_q;

endmodule

@@ sv/gso3_mul.sv @@
// Two-stage unsigned multiplier built from 32x32 partial products.
module gso3_mul
  import gso3_pkg::*;
#(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [AW-1:0] a_i,
  input  logic [BW-1:0] b_i,
  output logic [AW+BW-1:0] p_o
);

  localparam int KA = (AW + LIMB - 1) / LIMB;
  localparam int KB = (BW + LIMB - 1) / LIMB;
  localparam int AP = KA * LIMB;
  localparam int BP = KB * LIMB;
  localparam int PW = AW + BW;

  logic [AP-1:0]      a_ext;
  logic [BP-1:0]      b_ext;
  logic [2*LIMB-1:0]  pp_q [KA*KB];
  logic [AP+BP-1:0]   acc;
  logic [PW-1:0]      p_q;

  assign a_ext = AP'(a_i);
  assign b_ext = BP'(b_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < KA; i++) begin
        for (int j = 0; j < KB; j++) begin
          pp_q[i*KB+j] <= a_ext[i*LIMB +: LIMB] * b_ext[j*LIMB +: LIMB];
        end
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int i = 0; i < KA; i++) begin
      for (int j = 0; j < KB; j++) begin
        acc = acc + ((AP+BP)'(pp_q[i*KB+j]) << (LIMB*(i+j)));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= acc[PW-1:0];
    end
  end

  assign p_o = p_q;

endmodule

@@ sv/gso3_isqrt.sv @@
// Pipelined integer square root, one result bit per stage, with a side tag.
module gso3_isqrt
  import gso3_pkg::*;
#(
  parameter int TW = 1
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [SQ_W-1:0]   x_i,
  input  logic [TW-1:0]     tag_i,
  output logic [ROOT_W-1:0] s_o,
  output logic [TW-1:0]     tag_o
);

  localparam int RW = ROOT_W + 3;

  logic [RW-1:0]     r_q   [SQRT_STEPS];
  logic [ROOT_W-1:0] q_q   [SQRT_STEPS];
  logic [SQ_W-1:0]   x_q   [SQRT_STEPS];
  logic [TW-1:0]     tag_q [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    logic [RW-1:0]     r_in, r2, t;
    logic [ROOT_W-1:0] q_in;
    logic [SQ_W-1:0]   x_in;
    logic [TW-1:0]     tg_in;
    logic              ge;

    if (k == 0) begin : g_first
      assign r_in  = '0;
      assign q_in  = '0;
      assign x_in  = x_i;
      assign tg_in = tag_i;
    end else begin : g_next
      assign r_in  = r_q[k-1];
      assign q_in  = q_q[k-1];
      assign x_in  = x_q[k-1];
      assign tg_in = tag_q[k-1];
    end

    assign r2 = {r_in[RW-3:0], x_in[SQ_W-1 -: 2]};
    assign t  = RW'({q_in, 2'b01});
    assign ge = (r2 >= t);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k]   <= ge ? (r2 - t) : r2;
        q_q[k]   <= {q_in[ROOT_W-2:0], ge};
        x_q[k]   <= x_in << 2;
        tag_q[k] <= tg_in;
      end
    end
  end

  assign s_o   = q_q[SQRT_STEPS-1];
  assign tag_o = tag_q[SQRT_STEPS-1];

endmodule

@@ sv/gso3_div.sv @@
// Pipelined restoring divider for one lane, quotient saturated at one in Q1.30.
module gso3_div
  import gso3_pkg::*;
(
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [ROOT_W-1:0] den_i,
  output logic [UNIT_W-1:0] q_o
);

  logic [ROOT_W-1:0]    rem_q [DIV_STEPS];
  logic [DIV_STEPS-1:0] bit_q [DIV_STEPS];
  logic [UNIT_W-1:0]    quo_q [DIV_STEPS];
  logic [ROOT_W-1:0]    den_q [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [ROOT_W-1:0]    rem_in, den_in;
    logic [DIV_STEPS-1:0] bit_in;
    logic [UNIT_W-1:0]    quo_in;
    logic [ROOT_W:0]      r2, diff;
    logic                 ge;

    if (k == 0) begin : g_first
      // the top bits stay below the divisor, so they seed the remainder
      assign rem_in = ROOT_W'(num_i[NUM_W-1:DIV_STEPS]);
      assign bit_in = num_i[DIV_STEPS-1:0];
      assign quo_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign bit_in = bit_q[k-1];
      assign quo_in = quo_q[k-1];
      assign den_in = den_q[k-1];
    end

    assign r2   = {rem_in, bit_in[DIV_STEPS-1]};
    assign diff = r2 - {1'b0, den_in};
    assign ge   = (r2 >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? diff[ROOT_W-1:0] : r2[ROOT_W-1:0];
        bit_q[k] <= bit_in << 1;
        quo_q[k] <= {quo_in[UNIT_W-2:0], ge};
        den_q[k] <= den_in;
      end
    end
  end

  assign q_o = (quo_q[DIV_STEPS-1] > ONE_Q30) ? ONE_Q30 : quo_q[DIV_STEPS-1];

endmodule

@@ sv/gso3_chk.sv @@
// Port-level checks for the Gram-Schmidt block, bound to the top level.
module gso3_chk
  import gso3_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_tvalid_o,
  input logic                m_tready_i,
  input logic [3*UNIT_W-1:0] m_tdata_o,
  input logic [STATUS_W-1:0] m_tuser_o
);

  // a failed item carries no vector
  a_zero_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tuser_o != ST_OK |-> m_tdata_o == '0)
    else $error("non-zero vector with failing status");

  // the x component of a good item lies within plus or minus one
  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tuser_o == ST_OK |->
      ($signed(m_tdata_o[UNIT_W-1:0]) <= $signed(ONE_Q30)) &&
      ($signed(m_tdata_o[UNIT_W-1:0]) >= -$signed(ONE_Q30)))
    else $error("unit_x out of range");

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o)
    else $error("result word withdrawn");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> $stable(m_tdata_o) && $stable(m_tuser_o))
    else $error("stalled result word changed");

endmodule

bind gram_schmidt_orthonormalise3_core gso3_chk u_gso3_chk (.*);
